[design/fcca_pkg.sv]
// fcca_pkg: shared constants for the cluster chain allocator
// no dependencies
`default_nettype none
package fcca_pkg;
    localparam int TableEntries = 8192;
    localparam int IdxW = $clog2(TableEntries);
    localparam int ChainLimit = 32;
    localparam int ListW = $clog2(ChainLimit);
    localparam int CntW = 6;
    localparam logic [15:0] END_MARK = 16'hFFF8;
    localparam logic [1:0] OP_WRITE = 2'd0;
    localparam logic [1:0] OP_READ = 2'd1;
    localparam logic [1:0] OP_REPLACE = 2'd2;
endpackage
`default_nettype wire

[design/fcca_ram.sv]
// fcca_ram: generic single-port ram with registered read
// no dependencies
`default_nettype none
module fcca_ram #(
    parameter int Width = 16,
    parameter int Depth = 1024
) (
    input  wire logic                     aclk,
    input  wire logic                     we,
    input  wire logic [$clog2(Depth)-1:0] addr,
    input  wire logic [Width-1:0]         wdata,
    output logic [Width-1:0]              rdata
);
    logic [Width-1:0] mem [Depth];
    // write-first is not needed; read old data
    always_ff @(posedge aclk) begin
        if (we) mem[addr] <= wdata;
        rdata <= mem[addr];
    end
endmodule
`default_nettype wire

[design/fat_cluster_chain_allocator.sv]
// fat_cluster_chain_allocator: FAT16 table with chain replace sequencer
// uses fcca_pkg and fcca_ram (table, old list, new list)
//
// Usage: one input beat (s_opcode, s_cluster_index, s_entry_value,
// s_cluster_count) on a valid/ready channel; results leave on m_ with
// m_last_result set on the final beat of each operation.
// A write gives its beat in the cycle after acceptance; a read gives its
// beat from S_RD, which takes the registered table data. Replace walks the
// old chain through S_WK and S_WKW, scans the table from cluster 2 at one
// entry per cycle until enough free entries are found, then links the new
// chain through S_NL, S_NLW and S_NLW2, emitting one beat per cluster; on
// no room it relinks the old chain through S_RL, S_RLW and S_OUT instead.
// The scan of the single-port table sets the worst case.
// One operation is handled at a time; s_ready is low while one is in work.
// The result register holds a beat while m_ready is low and the sequencer
// waits. Reset returns the sequencer to idle; the table contents are kept
// and are undefined until written. Opcode 3 is consumed with no result.
`default_nettype none
module fat_cluster_chain_allocator
    import fcca_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_valid,
    output logic             s_ready,
    input  wire logic [1:0]  s_opcode,
    input  wire logic [12:0] s_cluster_index,
    input  wire logic [15:0] s_entry_value,
    input  wire logic [5:0]  s_cluster_count,
    output logic             m_valid,
    input  wire logic        m_ready,
    output logic [15:0]      m_result_value,
    output logic             m_status,
    output logic             m_last_result
);
    localparam logic [3:0] S_IDLE = 4'd0, S_RD = 4'd1, S_RDW = 4'd2, S_WK = 4'd3,
        S_WKW = 4'd4, S_SC = 4'd5, S_SCW = 4'd6, S_RL = 4'd7, S_RLW = 4'd8,
        S_NL = 4'd9, S_NLW = 4'd10, S_NLW2 = 4'd11, S_OUT = 4'd12;

    logic [3:0]       st_reg, st_next;
    logic [IdxW-1:0]  c_reg, c_next;
    logic [15:0]      v_reg, v_next;
    logic [CntW-1:0]  cnt_reg, cnt_next;
    logic [ListW:0]   n_reg, n_next;   // old chain length
    logic [ListW:0]   k_reg, k_next;   // found / link index
    logic             ov_reg, ov_next;
    logic [15:0]      ov_val_reg, ov_val_next;
    logic             ost_reg, ost_next, ol_reg, ol_next;

    logic             t_we;
    logic [IdxW-1:0]  t_addr;
    logic [15:0]      t_wd, t_rd;
    logic             o_we, nw_we;
    logic [ListW-1:0] o_addr, nw_addr;
    logic [IdxW-1:0]  o_wd, nw_wd, o_rd, nw_rd;

    fcca_ram #(.Width(16), .Depth(TableEntries)) u_tab (
        .aclk(aclk), .we(t_we), .addr(t_addr), .wdata(t_wd), .rdata(t_rd));
    fcca_ram #(.Width(IdxW), .Depth(ChainLimit)) u_old (
        .aclk(aclk), .we(o_we), .addr(o_addr), .wdata(o_wd), .rdata(o_rd));
    fcca_ram #(.Width(IdxW), .Depth(ChainLimit)) u_new (
        .aclk(aclk), .we(nw_we), .addr(nw_addr), .wdata(nw_wd), .rdata(nw_rd));

    assign s_ready = (st_reg == S_IDLE) && !ov_reg;
    assign m_valid = ov_reg;
    assign m_result_value = ov_val_reg;
    assign m_status = ost_reg;
    assign m_last_result = ol_reg;

    logic walk_ok;
    assign walk_ok = (c_reg >= IdxW'(2));

    // sequencer
    always_comb begin
        st_next = st_reg; c_next = c_reg; v_next = v_reg; cnt_next = cnt_reg;
        n_next = n_reg; k_next = k_reg;
        ov_next = ov_reg && !m_ready; ov_val_next = ov_val_reg;
        ost_next = ost_reg; ol_next = ol_reg;
        t_we = 1'b0; t_addr = c_reg; t_wd = 16'd0;
        o_we = 1'b0; o_addr = n_reg[ListW-1:0]; o_wd = c_reg;
        nw_we = 1'b0; nw_addr = k_reg[ListW-1:0]; nw_wd = c_reg;
        unique case (st_reg)
            S_IDLE: begin
                t_addr = s_cluster_index;
                if (s_valid && s_ready) begin
                    c_next = s_cluster_index; v_next = s_entry_value;
                    cnt_next = s_cluster_count; n_next = '0; k_next = '0;
                    unique case (s_opcode)
                        OP_WRITE: begin
                            t_we = 1'b1; t_wd = s_entry_value;
                            ov_next = 1'b1; ov_val_next = 16'd0;
                            ost_next = 1'b0; ol_next = 1'b1;
                        end
                        OP_READ: st_next = S_RD;
                        OP_REPLACE: begin
                            if (s_cluster_count > CntW'(ChainLimit)) begin
                                ov_next = 1'b1; ov_val_next = 16'd0;
                                ost_next = 1'b1; ol_next = 1'b1;
                            end else if (s_cluster_index >= IdxW'(2)) begin
                                st_next = S_WKW;
                            end else begin
                                c_next = IdxW'(2); v_next = 16'd0; st_next = S_WK;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RD: begin
                ov_next = 1'b1; ov_val_next = t_rd; ost_next = 1'b0;
                ol_next = 1'b1; st_next = S_IDLE;
            end
            // walk old chain: table read issued, data now valid
            S_WKW: begin
                o_we = 1'b1; t_we = 1'b1; t_wd = 16'd0;
                n_next = n_reg + 1'b1;
                if (t_rd >= END_MARK || t_rd < 16'd2 || t_rd >= 16'(TableEntries)
                    || n_reg + 1'b1 >= (ListW+1)'(ChainLimit) || !walk_ok) begin
                    c_next = IdxW'(2); v_next = 16'd0; st_next = S_WK;
                end else begin
                    c_next = t_rd[IdxW-1:0]; st_next = S_WK;
                    v_next = 16'hFFFF;  // flag: continue walk
                end
            end
            S_WK: begin
                if (v_reg == 16'hFFFF) begin
                    v_next = 16'd0; st_next = S_WKW;
                end else if (cnt_reg == '0) begin
                    ov_next = 1'b1; ov_val_next = 16'd0; ost_next = 1'b0;
                    ol_next = 1'b1; st_next = S_IDLE;
                end else st_next = S_SCW;
            end
            // scan: issue read at c_reg
            S_SCW: st_next = S_SC;
            S_SC: begin
                if (t_rd == 16'd0) begin
                    nw_we = 1'b1; k_next = k_reg + 1'b1;
                end
                if (t_rd == 16'd0 && k_reg + 1'b1 == (ListW+1)'(cnt_reg)) begin
                    k_next = '0; st_next = S_NL;
                end else if (c_reg == IdxW'(TableEntries - 1)) begin
                    k_next = '0; st_next = S_RL;
                    if (n_reg == '0) begin
                        ov_next = 1'b1; ov_val_next = 16'd0; ost_next = 1'b1;
                        ol_next = 1'b1; st_next = S_IDLE;
                    end
                end else begin
                    c_next = c_reg + 1'b1; t_addr = c_reg + 1'b1;
                end
            end
            // relink old chain: read old[k], old[k+1]
            S_RL: begin
                o_addr = k_reg[ListW-1:0]; st_next = S_RLW;
            end
            S_RLW: begin
                o_addr = ListW'(k_reg + 1'b1);
                c_next = o_rd; st_next = S_OUT;
            end
            S_OUT: begin
                t_addr = c_reg; t_we = 1'b1;
                t_wd = (k_reg + 1'b1 < n_reg) ? 16'(o_rd) : END_MARK;
                k_next = k_reg + 1'b1;
                if (k_reg + 1'b1 >= n_reg) begin
                    ov_next = 1'b1; ov_val_next = 16'd0; ost_next = 1'b1;
                    ol_next = 1'b1; st_next = S_IDLE;
                end else st_next = S_RL;
            end
            // link new chain, one beat per cluster
            S_NL: begin
                nw_addr = k_reg[ListW-1:0];
                if (!ov_next) st_next = S_NLW;
            end
            S_NLW: begin
                nw_addr = ListW'(k_reg + 1'b1);
                c_next = nw_rd; st_next = S_NLW2;
            end
            S_NLW2: begin
                t_addr = c_reg; t_we = 1'b1;
                t_wd = (k_reg + 1'b1 < (ListW+1)'(cnt_reg)) ? 16'(nw_rd) : END_MARK;
                ov_next = 1'b1; ov_val_next = 16'(c_reg); ost_next = 1'b0;
                ol_next = (k_reg + 1'b1 == (ListW+1)'(cnt_reg));
                k_next = k_reg + 1'b1;
                st_next = ol_next ? S_IDLE : S_NL;
            end
            default: st_next = S_IDLE;
        endcase
    end

    // state registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_reg <= S_IDLE; ov_reg <= 1'b0;
        end else begin
            st_reg <= st_next; ov_reg <= ov_next;
        end
        c_reg <= c_next; v_reg <= v_next; cnt_reg <= cnt_next;
        n_reg <= n_next; k_reg <= k_next; ov_val_reg <= ov_val_next;
        ost_reg <= ost_next; ol_reg <= ol_next;
    end
endmodule
`default_nettype wire

[sim/testbench.sv]
// testbench: self-checking bench for fat_cluster_chain_allocator
// depends on fcca_pkg and the design sources under design/
`timescale 1ns / 100ps

module testbench;
    import fcca_pkg::*;

    localparam int  LoadBeats  = TableEntries;
    localparam int  RandItems  = 100;
    localparam int  TailCycles = 20;
    localparam int  LongHold   = 3000;
    localparam longint CycleLimit = 12000000;

    typedef struct {
        logic [1:0]  op;
        logic [12:0] idx;
        logic [15:0] val;
        logic [5:0]  cnt;
        bit          burst;
    } op_beat_t;

    typedef struct {
        logic [15:0] value;
        logic        status;
        logic        last;
    } result_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_opcode;
    logic [12:0] s_cluster_index;
    logic [15:0] s_entry_value;
    logic [5:0]  s_cluster_count;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_result_value;
    logic        m_status;
    logic        m_last_result;

    fat_cluster_chain_allocator i_dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready),
        .s_opcode(s_opcode), .s_cluster_index(s_cluster_index),
        .s_entry_value(s_entry_value), .s_cluster_count(s_cluster_count),
        .m_valid(m_valid), .m_ready(m_ready),
        .m_result_value(m_result_value), .m_status(m_status),
        .m_last_result(m_last_result)
    );

    // shadow copy of the allocation table and expected result beats
    logic [15:0] fat_shadow [0:TableEntries-1];
    result_t     beats_due [$];
    op_beat_t    op_queue [$];
    logic [12:0] chain_heads [$];

    int     errors = 0;
    int     accepted = 0;
    int     replaces = 0;
    int     no_room = 0;
    int     results_seen = 0;
    longint cycles = 0;
    bit     took = 0;
    bit     long_hold_req = 0;
    bit     cur_burst = 1;

    // clock
    initial begin
        aclk = 0;
        forever #6 aclk = ~aclk;
    end

    // timeout watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > CycleLimit) begin
            $display("timeout after %0d cycles", cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic void push_due(logic [15:0] v, logic st, logic last);
        result_t r;
        r.value = v;
        r.status = st;
        r.last = last;
        beats_due.push_back(r);
    endfunction

    // free the old chain, find free clusters, then link or restore
    function automatic void predict_replace(logic [12:0] start, logic [5:0] cnt);
        logic [12:0] freed [$];
        logic [12:0] grabbed [$];
        int c;
        logic [15:0] nxt;
        replaces++;
        if (cnt > ChainLimit) begin
            no_room++;
            push_due(16'd0, 1'b1, 1'b1);
            return;
        end
        c = start;
        while (c >= 2 && c < TableEntries && freed.size() < ChainLimit) begin
            nxt = fat_shadow[c];
            freed.push_back(13'(c));
            fat_shadow[c] = 16'd0;
            if (nxt >= END_MARK) break;
            c = nxt;
        end
        for (c = 2; c < TableEntries && grabbed.size() < cnt; c++)
            if (fat_shadow[c] == 16'd0) grabbed.push_back(13'(c));
        if (grabbed.size() < cnt) begin
            foreach (freed[i])
                fat_shadow[freed[i]] = (i + 1 < freed.size()) ? 16'(freed[i+1]) : END_MARK;
            no_room++;
            push_due(16'd0, 1'b1, 1'b1);
            return;
        end
        if (cnt == 0) begin
            push_due(16'd0, 1'b0, 1'b1);
            return;
        end
        foreach (grabbed[i]) begin
            fat_shadow[grabbed[i]] = (i + 1 < cnt) ? 16'(grabbed[i+1]) : END_MARK;
            push_due(16'(grabbed[i]), 1'b0, (i + 1 == cnt));
        end
        chain_heads.push_back(grabbed[0]);
    endfunction

    function automatic void predict_op(op_beat_t b);
        case (b.op)
            OP_WRITE: begin
                fat_shadow[b.idx] = b.val;
                push_due(16'd0, 1'b0, 1'b1);
            end
            OP_READ: push_due(fat_shadow[b.idx], 1'b0, 1'b1);
            OP_REPLACE: predict_replace(b.idx, b.cnt);
            default: ;
        endcase
    endfunction

    function automatic int pick_gap(bit burst);
        int r;
        if (burst) return 0;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(20, 300);
    endfunction

    // input side monitor: predict every accepted beat
    always @(posedge aclk) begin
        op_beat_t b;
        took = aresetn && s_valid && s_ready;
        if (took) begin
            b.op = s_opcode;
            b.idx = s_cluster_index;
            b.val = s_entry_value;
            b.cnt = s_cluster_count;
            b.burst = 0;
            predict_op(b);
            accepted++;
            if (accepted == LoadBeats + 30) long_hold_req = 1;
        end
    end

    // result monitor: compare against the oldest expected beat
    always @(posedge aclk) begin
        result_t e;
        if (aresetn && m_valid && m_ready) begin
            results_seen++;
            if (beats_due.size() == 0) begin
                errors++;
                $display("%0t: unexpected beat value=%h status=%b last=%b",
                         $time, m_result_value, m_status, m_last_result);
            end else begin
                e = beats_due.pop_front();
                if (m_result_value !== e.value || m_status !== e.status ||
                    m_last_result !== e.last) begin
                    errors++;
                    $display("%0t: expected value=%h status=%b last=%b,",
                             $time, e.value, e.status, e.last,
                             " got value=%h status=%b last=%b",
                             m_result_value, m_status, m_last_result);
                end
            end
        end
    end

    // input driver
    int gap = 0;
    always @(negedge aclk) begin
        op_beat_t b;
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_opcode <= OP_WRITE;
            s_cluster_index <= '0;
            s_entry_value <= '0;
            s_cluster_count <= '0;
        end else if (!s_valid || took) begin
            if (gap > 0) begin
                gap--;
                s_valid <= 1'b0;
            end else if (op_queue.size() != 0) begin
                b = op_queue.pop_front();
                s_opcode <= b.op;
                s_cluster_index <= b.idx;
                s_entry_value <= b.val;
                s_cluster_count <= b.cnt;
                s_valid <= 1'b1;
                gap = pick_gap(b.burst);
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // result side back-pressure, with one long hold-off
    int hold = 0;
    always @(negedge aclk) begin
        int r;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold > 0) begin
            hold--;
            m_ready <= 1'b0;
        end else if (long_hold_req) begin
            long_hold_req = 0;
            hold = LongHold;
            m_ready <= 1'b0;
        end else if (cur_burst) begin
            m_ready <= 1'b1;
        end else begin
            r = $urandom_range(0, 99);
            if (r < 4) hold = $urandom_range(20, 200);
            else if (r < 30) hold = $urandom_range(0, 3);
            m_ready <= (hold == 0);
        end
    end

    function automatic void queue_op(logic [1:0] op, logic [12:0] idx, logic [15:0] val,
                                     logic [5:0] cnt, bit burst);
        op_beat_t b;
        b.op = op;
        b.idx = idx;
        b.val = val;
        b.cnt = cnt;
        b.burst = burst;
        op_queue.push_back(b);
    endfunction

    function automatic logic [5:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 70) return 6'($urandom_range(1, 8));
        if (r < 95) return 6'($urandom_range(0, 33));
        return 6'd63;
    endfunction

    function automatic logic [12:0] pick_head();
        if (chain_heads.size() == 0) return 13'($urandom_range(0, TableEntries - 1));
        return chain_heads[$urandom_range(0, chain_heads.size() - 1)];
    endfunction

    initial begin
        int r;
        logic [15:0] v;
        aresetn = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // load the whole table: mostly used entries, a sparse set of free ones
        for (int i = 0; i < TableEntries; i++) begin
            if (i % 40 == 7) v = 16'd0;
            else begin
                v = 16'($urandom_range(1, 16'hFFFF));
            end
            queue_op(OP_WRITE, 13'(i), v, 6'($urandom_range(0, 63)), 1);
        end
        wait (op_queue.size() == 0 && beats_due.size() == 0);
        cur_burst = 0;

        // directed: extremes and the special cases
        queue_op(OP_WRITE, 13'd0, 16'hFFFF, 6'd0, 0);
        queue_op(OP_READ, 13'd0, 16'h0000, 6'd63, 0);
        queue_op(OP_WRITE, 13'd8191, 16'h0000, 6'd0, 0);
        queue_op(OP_READ, 13'd8191, 16'hFFFF, 6'd0, 0);
        queue_op(OP_WRITE, 13'd1, 16'd0, 6'd0, 0);
        queue_op(OP_REPLACE, 13'd0, 16'd0, 6'd3, 0);      // no old chain
        queue_op(OP_REPLACE, 13'd1, 16'd0, 6'd0, 0);      // count zero, no chain
        queue_op(OP_REPLACE, 13'd7, 16'd0, 6'd33, 0);     // count too large
        queue_op(OP_REPLACE, 13'd7, 16'd0, 6'd63, 0);
        queue_op(OP_REPLACE, 13'd2, 16'd0, 6'd32, 0);     // full size chain
        queue_op(OP_READ, 13'd2, 16'd0, 6'd0, 0);
        queue_op(OP_REPLACE, 13'd8191, 16'd0, 6'd1, 0);   // chain at table end
        queue_op(OP_WRITE, 13'd8191, 16'hFFF8, 6'd0, 0);  // end marker entry
        queue_op(OP_REPLACE, 13'd8191, 16'd0, 6'd0, 0);
        queue_op(2'd3, 13'h1FFF, 16'hFFFF, 6'd63, 0);     // unused opcode
        queue_op(OP_WRITE, 13'd100, 16'd8000, 6'd0, 0);   // link far into table
        queue_op(OP_REPLACE, 13'd100, 16'd0, 6'd2, 0);
        wait (op_queue.size() == 0 && !s_valid && beats_due.size() == 0);
        queue_op(OP_REPLACE, pick_head(), 16'd0, 6'd32, 0);
        queue_op(OP_REPLACE, pick_head(), 16'd0, 6'd32, 0);
        queue_op(OP_REPLACE, pick_head(), 16'd0, 6'd32, 0);

        // random part, mostly replaces, most of them of chains allocated earlier
        for (int n = 0; n < RandItems; n++) begin
            wait (op_queue.size() < 2);
            r = $urandom_range(0, 99);
            if (r < 40)
                queue_op(OP_REPLACE, pick_head(), 16'($urandom), pick_count(), 0);
            else if (r < 52)
                queue_op(OP_REPLACE, 13'($urandom), 16'($urandom), pick_count(), 0);
            else if (r < 72)
                queue_op(OP_READ, (r & 1) ? pick_head() : 13'($urandom), 16'($urandom),
                         6'($urandom), 0);
            else if (r < 95)
                queue_op(OP_WRITE, 13'($urandom),
                         (r & 1) ? 16'($urandom) : 16'($urandom_range(0, 2)),
                         6'($urandom), 0);
            else
                queue_op(2'd3, 13'($urandom), 16'($urandom), 6'($urandom), 0);
        end

        wait (op_queue.size() == 0 && !s_valid && beats_due.size() == 0);
        repeat (TailCycles) @(posedge aclk);
        $display("covered %0d accepted beats, %0d replaces (%0d refused), %0d result beats",
                 accepted, replaces, no_room, results_seen);
        if (errors == 0 && beats_due.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d errors, %0d beats still due", errors, beats_due.size());
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
